### rtl/assert_macros.svh
// Assertion helpers. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GPE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpe assertion failed");

// Next-cycle implication.
`define GPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpe assertion failed");

`endif

### rtl/gpe_pkg.sv
package gpe_pkg;

    localparam int STORE_DEPTH_DEF = 35;

    localparam int LIMIT_W = 21;
    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 21'd2000000;

    // Characters
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [31:0] ASCII_ZERO = 32'd48;

    // 60 minutes * 1e4 per degree, 1e4 per minute
    localparam logic [31:0] DEG_SCALE = 32'd600000;
    localparam logic [31:0] MIN_SCALE = 32'd10000;

    // Sentence positions that feed the decode, in snapshot order.
    localparam int NUM_KEPT = 19;
    localparam int KEPT_POS [NUM_KEPT] = '{
        11, 12, 13, 14, 16, 17, 18, 19, 21,
        23, 24, 25, 26, 27, 29, 30, 31, 32, 34
    };

    // Snapshot slot indexes
    localparam int LAT_DEG0 = 0;
    localparam int LAT_MIN0 = 2;
    localparam int LAT_FRC0 = 4;
    localparam int LAT_HEMI = 8;
    localparam int LON_DEG0 = 9;
    localparam int LON_MIN0 = 12;
    localparam int LON_FRC0 = 14;
    localparam int LON_HEMI = 18;

    typedef logic [NUM_KEPT-1:0][7:0] snap_t;

    // Parser -> decode
    typedef struct packed {
        logic  vld;
        logic  timeout;
        snap_t snap;
    } event_t;

    // Decode -> output stage
    typedef struct packed {
        logic        vld;
        logic        timeout;
        logic        lat_neg;
        logic        lon_neg;
        logic [31:0] lat_mag;
        logic [31:0] lon_mag;
    } pre_res_t;

    function automatic logic [31:0] digit(input logic [7:0] b);
        return {24'd0, b} - ASCII_ZERO;
    endfunction

endpackage

### rtl/gpe_ifs.sv
interface gpe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gpe_res_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;

    modport source (output valid, output status, output latitude, output longitude,
                    input ready);
    modport sink   (input valid, input status, input latitude, input longitude,
                    output ready);
endinterface

interface gpe_cfg_if;
    logic        valid;
    logic        ready;
    logic [20:0] timeout_limit;

    modport source (output valid, output timeout_limit, input ready);
    modport sink   (input valid, input timeout_limit, output ready);
endinterface

### rtl/gpe_parser.sv
module gpe_parser #(
    parameter int STORE_DEPTH = gpe_pkg::STORE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        byte_vld,
    input  logic [7:0]                  byte_in,
    input  logic [gpe_pkg::LIMIT_W-1:0] limit,
    output gpe_pkg::event_t             ev
);

    localparam int POS_W = $clog2(STORE_DEPTH + 1);
    localparam logic [1:0] STEP_LAST = 2'd2;
    localparam logic [gpe_pkg::LIMIT_W-1:0] ATT_ONE = {{(gpe_pkg::LIMIT_W-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_DROP   = 3'b010,
        PH_STORE  = 3'b100
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [1:0]                  step_reg, step_next;
    logic [gpe_pkg::LIMIT_W-1:0] att_reg, att_next, att_inc;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [7:0]                  kept_reg [gpe_pkg::NUM_KEPT];
    logic [gpe_pkg::NUM_KEPT-1:0] hit;
    gpe_pkg::snap_t              snap;
    gpe_pkg::event_t             ev_reg;
    logic                        step_en;
    logic                        wr_en;
    logic                        fire;
    logic                        timeout;
    logic [7:0]                  want;

    assign step_en = adv && byte_vld;
    assign att_inc = att_reg + ATT_ONE;
    assign want    = (step_reg == STEP_LAST) ? gpe_pkg::CH_A : gpe_pkg::CH_G;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        att_next   = att_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        fire       = 1'b0;
        timeout    = 1'b0;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (byte_in == want)
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        phase_next = PH_DROP;
                        step_next  = 2'd0;
                        pos_next   = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 2'd1;
                    end
                end
                else
                begin
                    // failed attempt, no resync
                    step_next = 2'd0;
                    att_next  = att_inc;
                    if (att_inc >= limit)
                    begin
                        fire    = 1'b1;
                        timeout = 1'b1;
                    end
                end
            end
            PH_DROP:
            begin
                if (byte_in == gpe_pkg::CH_STAR)
                    fire = 1'b1;
                else
                    phase_next = PH_STORE;
            end
            PH_STORE:
            begin
                if (pos_reg < POS_W'(STORE_DEPTH))
                begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                end
                if (byte_in == gpe_pkg::CH_STAR)
                    fire = 1'b1;
            end
            default:
            begin
                phase_next = PH_SEARCH;
                step_next  = 2'd0;
                att_next   = '0;
                pos_next   = '0;
            end
        endcase
        if (fire)
        begin
            phase_next = PH_SEARCH;
            step_next  = 2'd0;
            att_next   = '0;
            pos_next   = '0;
        end
    end

    // Snapshot sees the byte written this beat (the closing '*' may land in a field).
    for (genvar i = 0; i < gpe_pkg::NUM_KEPT; i++)
    begin : g_kept
        assign hit[i]  = wr_en && (pos_reg == POS_W'(gpe_pkg::KEPT_POS[i]));
        assign snap[i] = hit[i] ? byte_in : kept_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                kept_reg[i] <= 8'd0;
            else if (step_en && hit[i])
                kept_reg[i] <= byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            step_reg  <= 2'd0;
            att_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            att_reg   <= att_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_reg <= '0;
        else if (adv)
        begin
            ev_reg.vld     <= step_en && fire;
            ev_reg.timeout <= timeout;
            ev_reg.snap    <= snap;
        end
    end

    assign ev = ev_reg;

endmodule

### rtl/gpe_decode.sv
module gpe_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  gpe_pkg::event_t    ev,
    output gpe_pkg::pre_res_t  pre
);

    // Stage A: digit groups
    logic        a_vld_reg, a_to_reg, a_lat_neg_reg, a_lon_neg_reg;
    logic [31:0] lat_deg_reg, lat_min_reg, lat_frc_reg;
    logic [31:0] lon_deg_reg, lon_min_reg, lon_frc_reg;
    logic [31:0] lat_deg, lat_min, lat_frc, lon_deg, lon_min, lon_frc;

    // Stage B: scaled sums
    gpe_pkg::pre_res_t pre_reg;

    always_comb
    begin
        lat_deg = gpe_pkg::digit(ev.snap[gpe_pkg::LAT_DEG0]) * 32'd10
                + gpe_pkg::digit(ev.snap[gpe_pkg::LAT_DEG0+1]);
        lat_min = gpe_pkg::digit(ev.snap[gpe_pkg::LAT_MIN0]) * 32'd10
                + gpe_pkg::digit(ev.snap[gpe_pkg::LAT_MIN0+1]);
        lat_frc = gpe_pkg::digit(ev.snap[gpe_pkg::LAT_FRC0]) * 32'd1000
                + gpe_pkg::digit(ev.snap[gpe_pkg::LAT_FRC0+1]) * 32'd100
                + gpe_pkg::digit(ev.snap[gpe_pkg::LAT_FRC0+2]) * 32'd10
                + gpe_pkg::digit(ev.snap[gpe_pkg::LAT_FRC0+3]);
        lon_deg = gpe_pkg::digit(ev.snap[gpe_pkg::LON_DEG0]) * 32'd100
                + gpe_pkg::digit(ev.snap[gpe_pkg::LON_DEG0+1]) * 32'd10
                + gpe_pkg::digit(ev.snap[gpe_pkg::LON_DEG0+2]);
        lon_min = gpe_pkg::digit(ev.snap[gpe_pkg::LON_MIN0]) * 32'd10
                + gpe_pkg::digit(ev.snap[gpe_pkg::LON_MIN0+1]);
        lon_frc = gpe_pkg::digit(ev.snap[gpe_pkg::LON_FRC0]) * 32'd1000
                + gpe_pkg::digit(ev.snap[gpe_pkg::LON_FRC0+1]) * 32'd100
                + gpe_pkg::digit(ev.snap[gpe_pkg::LON_FRC0+2]) * 32'd10
                + gpe_pkg::digit(ev.snap[gpe_pkg::LON_FRC0+3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= ev.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_to_reg      <= ev.timeout;
            a_lat_neg_reg <= (ev.snap[gpe_pkg::LAT_HEMI] != gpe_pkg::CH_N);
            a_lon_neg_reg <= (ev.snap[gpe_pkg::LON_HEMI] != gpe_pkg::CH_E);
            lat_deg_reg   <= lat_deg;
            lat_min_reg   <= lat_min;
            lat_frc_reg   <= lat_frc;
            lon_deg_reg   <= lon_deg;
            lon_min_reg   <= lon_min;
            lon_frc_reg   <= lon_frc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_reg <= '0;
        else if (adv)
        begin
            pre_reg.vld     <= a_vld_reg;
            pre_reg.timeout <= a_to_reg;
            pre_reg.lat_neg <= a_lat_neg_reg;
            pre_reg.lon_neg <= a_lon_neg_reg;
            pre_reg.lat_mag <= lat_deg_reg * gpe_pkg::DEG_SCALE
                             + lat_min_reg * gpe_pkg::MIN_SCALE + lat_frc_reg;
            pre_reg.lon_mag <= lon_deg_reg * gpe_pkg::DEG_SCALE
                             + lon_min_reg * gpe_pkg::MIN_SCALE + lon_frc_reg;
        end
    end

    assign pre = pre_reg;

endmodule

### rtl/gga_position_extractor.sv
// GGA position extractor.
// rx  : one received character per beat (rx_byte); accepted on valid && ready.
// res : one beat per decoded sentence or per search timeout. status 0 carries
//       latitude/longitude in 1e-4 arc minute (south/west negative); status 1
//       is a timeout and both coordinates read zero.
// cfg : timeout_limit write; always ready, write only while the block is idle.
// Throughput: one byte per cycle while rx.ready is high. The result of the byte
// that ends a sentence (or the failing byte) passes from the input register
// through the parse register, two decode stages and the output register to res.
// The whole pipeline moves together; rx.ready drops only while a result sits
// in the output register and res.ready is low, so no beat is lost or doubled.
// Reset: searching for "GGA", attempt count and position zero, stored sentence
// bytes zero, timeout_limit back to 2000000. Stored bytes are never cleared
// between sentences, so fields a short sentence leaves out decode from the
// previous sentence.
module gga_position_extractor #(
    parameter int STORE_DEPTH = gpe_pkg::STORE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gpe_byte_if.sink    rx,
    gpe_res_if.source   res,
    gpe_cfg_if.sink     cfg
);

    logic                        adv;
    logic                        byte_vld_reg;
    logic [7:0]                  byte_reg;
    logic [gpe_pkg::LIMIT_W-1:0] limit_reg;
    gpe_pkg::event_t             ev;
    gpe_pkg::pre_res_t           pre;

    logic                        out_vld_reg;
    logic                        out_status_reg;
    logic [31:0]                 out_lat_reg;
    logic [31:0]                 out_lon_reg;

    // Pipeline advances unless the output beat is stalled.
    assign adv      = !out_vld_reg || res.ready;
    assign rx.ready = adv;

    // Configuration: single register, always accepted.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= gpe_pkg::TIMEOUT_RESET;
        else if (cfg.valid)
            limit_reg <= cfg.timeout_limit;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_vld_reg <= 1'b0;
        else if (adv)
            byte_vld_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && rx.valid)
            byte_reg <= rx.rx_byte;
    end

    // Sentence scanner and field store
    gpe_parser #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .byte_vld (byte_vld_reg),
        .byte_in  (byte_reg),
        .limit    (limit_reg),
        .ev       (ev)
    );

    // Digit-to-value arithmetic
    gpe_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .ev    (ev),
        .pre   (pre)
    );

    // Output register: apply hemisphere sign, zero coordinates on timeout.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= pre.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv && pre.vld)
        begin
            out_status_reg <= pre.timeout;
            out_lat_reg    <= pre.timeout ? 32'd0 :
                              (pre.lat_neg ? (32'd0 - pre.lat_mag) : pre.lat_mag);
            out_lon_reg    <= pre.timeout ? 32'd0 :
                              (pre.lon_neg ? (32'd0 - pre.lon_mag) : pre.lon_mag);
        end
    end

    assign res.valid     = out_vld_reg;
    assign res.status    = out_status_reg;
    assign res.latitude  = $signed(out_lat_reg);
    assign res.longitude = $signed(out_lon_reg);

endmodule

### rtl/gpe_checker.sv
`include "assert_macros.svh"

module gpe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic               res_status,
    input logic signed [31:0] res_latitude,
    input logic signed [31:0] res_longitude
);

    logic [64:0] res_beat;

    assign res_beat = {res_status, res_latitude, res_longitude};

    // stalled result beat stays
    `GPE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
    `GPE_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_beat))

    // timeout beat carries no position
    `GPE_ASSERT_IMPL(a_timeout_zero, res_valid && res_status, res_latitude == 32'sd0 && res_longitude == 32'sd0)

    // empty output never blocks input; stalled output always does
    `GPE_ASSERT_IMPL(a_ready_when_empty, !res_valid, rx_ready)
    `GPE_ASSERT_IMPL(a_backpressure, res_valid && !res_ready, !rx_ready)

endmodule

bind gga_position_extractor gpe_checker u_gpe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_ready      (rx.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_status    (res.status),
    .res_latitude  (res.latitude),
    .res_longitude (res.longitude)
);
